FILE: rtl/ewma_zscore_rate_anomaly_unit_defines.svh
// Assertion macros shared by the anomaly unit RTL.
`ifndef EWMA_ZSCORE_RATE_ANOMALY_UNIT_DEFINES_SVH
`define EWMA_ZSCORE_RATE_ANOMALY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EWZR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ewzr check failed");
`define EWZR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ewzr check failed");
`else
`define EWZR_ASSERT_IMPL(lbl, ante, cons)
`define EWZR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/ewzr_pkg.sv
// Types and constants of the EWMA z-score anomaly unit.
`timescale 1ns / 1ps
package ewzr_pkg;
	localparam int METRICS = 3;
	localparam logic [1:0] LAST_METRIC = 2'd2;
	localparam logic [1:0] METRIC_NONE = 2'd3;
	localparam int MUL_A_W = 33;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_MIN_WINDOWS = 2'd1;
	localparam logic [1:0] REG_WINDOW_SECS = 2'd2;
	localparam logic [1:0] REG_Z_THRESHOLD = 2'd3;

	typedef struct packed {
		logic [15:0] alpha;
		logic [7:0]  learn_wins;
		logic [31:0] win_len;
		logic [15:0] z_thr;
	} cfg_t;
endpackage

FILE: rtl/ewzr_cfg.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ewzr_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output ewzr_pkg::cfg_t     cfg
);
	import ewzr_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alpha <= 16'd19661;
			cfg_q.learn_wins <= 8'd5;
			cfg_q.win_len <= 32'd60;
			cfg_q.z_thr <= 16'd768;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ALPHA: cfg_q.alpha <= pwdata[15:0];
				REG_MIN_WINDOWS: cfg_q.learn_wins <= pwdata[7:0];
				REG_WINDOW_SECS: cfg_q.win_len <= pwdata;
				REG_Z_THRESHOLD: cfg_q.z_thr <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ALPHA: prdata = {16'd0, cfg_q.alpha};
			REG_MIN_WINDOWS: prdata = {24'd0, cfg_q.learn_wins};
			REG_WINDOW_SECS: prdata = cfg_q.win_len;
			REG_Z_THRESHOLD: prdata = {16'd0, cfg_q.z_thr};
			default: prdata = 32'd0;
		endcase
	end
endmodule

FILE: rtl/ewzr_mul.sv
// Shared 33x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module ewzr_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ewzr_pkg::MUL_A_W-1:0]  a,
	input  logic [ewzr_pkg::MUL_B_W-1:0]  b,
	output logic [ewzr_pkg::MUL_P_W-1:0]  p
);
	import ewzr_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign p = p_q;
endmodule

FILE: rtl/ewma_zscore_rate_anomaly_unit.sv
// Per-process event rate tracker with EWMA mean/variance and z-score hit reporting.
// A count event reads the count memory in the cycle the beat is accepted and
// writes it back in the next one. A tick walks the slots one per cycle while a
// slot needs no fold; each metric of an elapsed slot is folded by the shared
// 33x32 multiplier in eleven steps (deviation square, mean, variance, threshold
// product) between memory read and writeback and advance. Hit beats leave through
// a pending register and an output register; the tick ends when the final hit, marked
// by tlast, is loaded into the output register. One item is worked on at a time.
`timescale 1ns / 1ps
`include "ewma_zscore_rate_anomaly_unit_defines.svh"
module ewma_zscore_rate_anomaly_unit #(
	parameter int SLOTS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,   // slot[3:0], metric[5:4], now_sec[37:6], zero pad
	input  logic         s_tuser,   // req_type
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // hit_slot, hit_metric, observed, prior_mean, variance
	output logic         m_tlast
);
	import ewzr_pkg::*;

	localparam int ENTRIES = METRICS * SLOTS;
	localparam int EW = $clog2(ENTRIES);
	localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_IDLE, ST_EVT_WR, ST_SLOT, ST_RD, ST_LOAD, ST_MUL, ST_WB, ST_EMIT, ST_ADV,
		ST_FLUSH
	} state_t;

	typedef enum logic [3:0] {
		MS_DD, MS_AX, MS_IO, MS_ASL, MS_ASH, MS_SUM, MS_ISL, MS_ISH, MS_ZZ, MS_PL, MS_PH
	} mstep_t;

	typedef struct packed {
		logic [47:0] variance;
		logic [31:0] prior_mean;
		logic [15:0] observed;
		logic [1:0]  metric;
		logic [3:0]  slot;
	} hit_t;

	cfg_t cfg;

	ewzr_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// Control state
	state_t state_q;
	mstep_t step_q;
	logic ph_q;
	logic [SIW-1:0] s_q;
	logic [1:0] k_q;
	logic [EW-1:0] e_q;
	logic [SLOTS-1:0] present_q, started_q;
	logic [ENTRIES-1:0] cnt_vld_q, stat_vld_q;
	logic ev_ok_q;
	logic [EW-1:0] ev_e_q;
	logic [SIW-1:0] ev_slot_q;
	logic pend_vld_q, m_tvalid_q, nh_hit_q;

	// Payload
	logic [31:0] now_q;
	logic [31:0] wb_q [SLOTS];
	logic [15:0] xc_q;
	logic [31:0] d_q;
	logic [63:0] d2_q;
	logic [81:0] acc_q;
	logic [31:0] mean_new_q;
	logic [47:0] t_q, sum_q, var_new_q;
	logic [31:0] zz_q;
	logic [48:0] v1_q;
	logic cmp_q;
	hit_t nh_q, pend_q, out_q;
	logic out_last_q;

	// Memories
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
	logic [31:0] mean_mem [ENTRIES];
	logic [47:0] var_mem [ENTRIES];
	logic [7:0] ws_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [31:0] mean_rd_q;
	logic [47:0] var_rd_q;
	logic [7:0] ws_rd_q;
	logic cnt_vld_rd_q, stat_vld_rd_q;

	logic s_acc;
	logic [3:0] in_slot;
	logic [1:0] in_metric;
	logic [6:0] ev_idx7;
	logic ev_ok;
	logic [EW-1:0] rd_addr;
	logic rd_in_rng;
	logic [COUNT_BITS-1:0] cnt_v;
	logic [31:0] mean_v;
	logic [47:0] var_v;
	logic [7:0] ws_v, ws_new;
	logic ws0;
	logic [31:0] cnt32;
	logic [15:0] xc;
	logic [31:0] x32;
	logic [16:0] inv;
	logic [47:0] sq;
	logic [48:0] sum49;
	logic mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic [81:0] prod_ext, acc_lo, acc_hi;
	logic last_slot;
	logic elapsed;
	logic out_free, out_load, pend_load;
	logic cnt_we;
	logic [EW-1:0] cnt_wa;
	logic [COUNT_BITS-1:0] cnt_wd;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc = s_tvalid && s_tready;
	assign in_slot = s_tdata[3:0];
	assign in_metric = s_tdata[5:4];
	assign ev_idx7 = 7'({in_slot, 1'b0}) + 7'(in_slot) + 7'(in_metric);
	assign ev_ok = ({1'b0, in_slot} < 5'(SLOTS)) && (in_metric != METRIC_NONE);
	assign rd_addr = (state_q == ST_IDLE) ? EW'(ev_idx7) : e_q;
	assign rd_in_rng = (rd_addr < EW'(ENTRIES));

	assign cnt_v = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign mean_v = stat_vld_rd_q ? mean_rd_q : 32'd0;
	assign var_v = stat_vld_rd_q ? var_rd_q : 48'd0;
	assign ws_v = stat_vld_rd_q ? ws_rd_q : 8'd0;
	assign ws0 = (ws_v == 8'd0);
	assign ws_new = (ws_v == 8'hFF) ? 8'hFF : ws_v + 8'd1;

	assign cnt32 = 32'(cnt_v);
	assign xc = (cnt32 > 32'h0000_FFFF) ? 16'hFFFF : cnt32[15:0];
	assign x32 = {xc_q, 16'd0};
	assign inv = 17'h1_0000 - {1'b0, cfg.alpha};
	assign sq = d2_q[63:16];
	assign sum49 = {1'b0, var_v} + {1'b0, t_q};

	assign last_slot = (s_q == SIW'(SLOTS - 1));
	assign elapsed = ((now_q - wb_q[s_q]) >= cfg.win_len);

	// Operand selection for the shared multiplier, one product per step.
	assign mul_en = (state_q == ST_MUL) && !ph_q;
	always_comb begin
		case (step_q)
			MS_DD: begin mul_a = 33'(d_q); mul_b = d_q; end
			MS_AX: begin mul_a = 33'(cfg.alpha); mul_b = x32; end
			MS_IO: begin mul_a = 33'(inv); mul_b = mean_v; end
			MS_ASL: begin mul_a = 33'(cfg.alpha); mul_b = sq[31:0]; end
			MS_ASH: begin mul_a = 33'(cfg.alpha); mul_b = 32'(sq[47:32]); end
			MS_ISL: begin mul_a = 33'(inv); mul_b = sum_q[31:0]; end
			MS_ISH: begin mul_a = 33'(inv); mul_b = 32'(sum_q[47:32]); end
			MS_ZZ: begin mul_a = 33'(cfg.z_thr); mul_b = 32'(cfg.z_thr); end
			MS_PL: begin mul_a = 33'(v1_q[31:0]); mul_b = zz_q; end
			MS_PH: begin mul_a = 33'(v1_q[48:32]); mul_b = zz_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	ewzr_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .p(mul_p));

	assign prod_ext = 82'(mul_p);
	assign acc_lo = acc_q + prod_ext;
	assign acc_hi = acc_q + (prod_ext << 32);

	assign out_free = !m_tvalid_q || m_tready;
	assign pend_load = (state_q == ST_EMIT) && (!pend_vld_q || out_free);
	assign out_load = ((state_q == ST_EMIT) || (state_q == ST_FLUSH)) && pend_vld_q && out_free;

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = ev_e_q;
		cnt_wd = (cnt_v == CNT_MAX) ? CNT_MAX : cnt_v + 1'b1;
		if (state_q == ST_EVT_WR && ev_ok_q) begin
			cnt_we = 1'b1;
		end else if (state_q == ST_WB) begin
			cnt_we = 1'b1;
			cnt_wa = e_q;
			cnt_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		cnt_rd_q <= cnt_mem[rd_addr];
		mean_rd_q <= mean_mem[rd_addr];
		var_rd_q <= var_mem[rd_addr];
		ws_rd_q <= ws_mem[rd_addr];
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (state_q == ST_WB) begin
			mean_mem[e_q] <= ws0 ? x32 : mean_new_q;
			var_mem[e_q] <= var_new_q;
			ws_mem[e_q] <= ws_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= MS_DD;
			ph_q <= 1'b0;
			s_q <= '0;
			k_q <= 2'd0;
			e_q <= '0;
			present_q <= '0;
			started_q <= '0;
			cnt_vld_q <= '0;
			stat_vld_q <= '0;
			cnt_vld_rd_q <= 1'b0;
			stat_vld_rd_q <= 1'b0;
			ev_ok_q <= 1'b0;
			ev_e_q <= '0;
			ev_slot_q <= '0;
			pend_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
			nh_hit_q <= 1'b0;
		end else begin
			cnt_vld_rd_q <= rd_in_rng && cnt_vld_q[rd_addr];
			stat_vld_rd_q <= rd_in_rng && stat_vld_q[rd_addr];
			if (cnt_we) begin
				cnt_vld_q[cnt_wa] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser) begin
							s_q <= '0;
							k_q <= 2'd0;
							e_q <= '0;
							state_q <= ST_SLOT;
						end else begin
							ev_ok_q <= ev_ok;
							ev_e_q <= EW'(ev_idx7);
							ev_slot_q <= SIW'(in_slot);
							state_q <= ST_EVT_WR;
						end
					end
				end
				ST_EVT_WR: begin
					if (ev_ok_q) begin
						present_q[ev_slot_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_SLOT: begin
					if (present_q[s_q] && started_q[s_q] && elapsed) begin
						k_q <= 2'd0;
						state_q <= ST_RD;
					end else begin
						if (present_q[s_q]) begin
							started_q[s_q] <= 1'b1;
						end
						e_q <= e_q + EW'(METRICS);
						if (last_slot) begin
							state_q <= ST_FLUSH;
						end else begin
							s_q <= s_q + 1'b1;
						end
					end
				end
				ST_RD: state_q <= ST_LOAD;
				ST_LOAD: begin
					step_q <= MS_DD;
					ph_q <= 1'b0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (!ph_q) begin
						ph_q <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						if (step_q == MS_PH) begin
							state_q <= ST_WB;
						end else begin
							step_q <= mstep_t'(step_q + 4'd1);
						end
					end
				end
				ST_WB: begin
					stat_vld_q[e_q] <= 1'b1;
					nh_hit_q <= cmp_q && (ws_new > cfg.learn_wins);
					state_q <= (cmp_q && (ws_new > cfg.learn_wins)) ? ST_EMIT : ST_ADV;
				end
				ST_EMIT: begin
					if (pend_load) begin
						pend_vld_q <= 1'b1;
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					e_q <= e_q + 1'b1;
					if (k_q == LAST_METRIC) begin
						k_q <= 2'd0;
						if (last_slot) begin
							state_q <= ST_FLUSH;
						end else begin
							s_q <= s_q + 1'b1;
							state_q <= ST_SLOT;
						end
					end else begin
						k_q <= k_q + 2'd1;
						state_q <= ST_RD;
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_vld_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the fold; each step consumes the product of its own operands, registered in its first phase.
	always_ff @(posedge clk) begin
		if (state_q == ST_SLOT && present_q[s_q] && (!started_q[s_q] || elapsed)) begin
			wb_q[s_q] <= now_q;
		end
		if (s_acc && s_tuser) begin
			now_q <= s_tdata[37:6];
		end
		if (state_q == ST_LOAD) begin
			xc_q <= xc;
			d_q <= ({xc, 16'd0} >= mean_v) ? {xc, 16'd0} - mean_v : mean_v - {xc, 16'd0};
		end
		if (state_q == ST_MUL && ph_q) begin
			case (step_q)
				MS_DD: d2_q <= mul_p[63:0];
				MS_AX: acc_q <= prod_ext + 82'd32768;
				MS_IO: mean_new_q <= acc_lo[47:16];
				MS_ASL: acc_q <= prod_ext;
				MS_ASH: t_q <= acc_hi[63:16];
				MS_SUM: sum_q <= sum49[48] ? VAR_MAX : sum49[47:0];
				MS_ISL: acc_q <= prod_ext;
				MS_ISH: var_new_q <= ws0 ? 48'd0 : acc_hi[63:16];
				MS_ZZ: begin
					zz_q <= mul_p[31:0];
					v1_q <= {1'b0, var_new_q} + 49'd1;
				end
				MS_PL: acc_q <= prod_ext;
				MS_PH: cmp_q <= ({18'd0, d2_q} >= acc_hi);
				default: ;
			endcase
		end
		if (state_q == ST_WB) begin
			nh_q.slot <= 4'(s_q);
			nh_q.metric <= k_q;
			nh_q.observed <= xc_q;
			nh_q.prior_mean <= mean_v;
			nh_q.variance <= var_new_q;
		end
		if (pend_load) begin
			pend_q <= nh_q;
		end
		if (out_load) begin
			out_q <= pend_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {2'b00, out_q};
	assign m_tlast = out_last_q;

	// The pending hit must have been handed on before the block takes a new item.
	`EWZR_ASSERT_IMPL(a_idle_no_pend, state_q == ST_IDLE, !pend_vld_q)
	// Fold reads only address real entries.
	`EWZR_ASSERT_IMPL(a_entry_rng, state_q == ST_RD, e_q < EW'(ENTRIES))
	// Only an entry that was just judged a hit is queued for output.
	`EWZR_ASSERT_IMPL(a_emit_hit, state_q == ST_EMIT, nh_hit_q)
	// An accepted count event leaves its entry marked as written.
	`EWZR_ASSERT_NEXT(a_evt_vld, state_q == ST_EVT_WR && ev_ok_q, cnt_vld_q[ev_e_q])
endmodule
